FILE: design/assert_macros.svh
// Assertion macros shared by the interval pair decoder RTL.
// Users include this file inside a module body that has clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while out of reset.
`define IPBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define IPBD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ipbd_pkg.sv
// Package for the interval pair bit decoder: payload structs,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ipbd_pkg;

  // Configuration register width and index width
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // Arrival timestamp width on the input channel
  localparam int ARRIVAL_W = 32;

  // Default internal time base width
  localparam int TIME_BITS_DEF = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] TOLERANCE_RST = CFG_W'(3500);
  localparam logic [CFG_W-1:0] SHORT_RST     = CFG_W'(10000);
  localparam logic [CFG_W-1:0] LONG_RST      = CFG_W'(30000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_SHORT     = 2'd1,
    CFG_LONG      = 2'd2
  } cfg_idx_t;

  // Input transaction payload
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival_us;
    logic                 has_timestamp;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic data_bit;
    logic pair_mismatch;
  } out_item_t;

endpackage

FILE: design/interval_pair_bit_decoder_top.sv
// Channel   | handshake            | payload
// ----------+----------------------+----------------------------------
// input     | in_valid / in_ready  | in_data  (arrival_us, has_timestamp)
// result    | out_valid / out_ready| out_data (data_bit, pair_mismatch)
// config    | cfg_we               | cfg_index, cfg_wdata (20 bits)
//
// An accepted transaction is latched in an input register, then decoded
// against the interval and symbol state once the output register can take a
// result; any result lands there. Sustained rate is one transaction per cycle
// while out_ready holds. Reset (rst_n, synchronous) clears valid flags and
// decoder state and loads the default windows. A stalled result register
// holds the input stage, which still takes a transaction while it is empty.
//
// Depends on ipbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module interval_pair_bit_decoder_top #(
  parameter int TIME_BITS = ipbd_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ipbd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ipbd_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ipbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipbd_pkg::CFG_W-1:0]          cfg_wdata
);

  import ipbd_pkg::*;

  `include "assert_macros.svh"

  // Compare width: wide enough for the interval and for nominal + tolerance
  localparam int CMP_W = (TIME_BITS > CFG_W + 1) ? TIME_BITS : CFG_W + 1;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ZERO = 2'd1,
    PEND_ONE  = 2'd2
  } pend_t;

  typedef enum logic {
    PHASE_FIRST  = 1'b0,
    PHASE_SECOND = 1'b1
  } phase_t;

  // Open window test: nom - tol < iv < nom + tol, lower bound dropped
  // when the tolerance exceeds the nominal value
  function automatic logic in_window(input logic [CMP_W-1:0] iv,
                                     input logic [CFG_W-1:0] nom,
                                     input logic [CFG_W-1:0] tol);
    logic [CMP_W-1:0] n;
    logic [CMP_W-1:0] t;
    n = CMP_W'(nom);
    t = CMP_W'(tol);
    return ((t > n) || (iv > n - t)) && (iv < n + t);
  endfunction

  // Configuration registers
  logic [CFG_W-1:0]     tol_r, short_r, long_r;

  // Input stage
  logic                 s1_valid_r, s1_valid_nxt;
  in_item_t             s1_data_r, s1_data_nxt;

  // Decoder state
  logic [TIME_BITS-1:0] last_arrival_r, last_arrival_nxt;
  logic [TIME_BITS-1:0] last_interval_r, last_interval_nxt;
  pend_t                pend_r, pend_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 held_r, held_nxt;

  // Output stage
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // Decode signals
  logic                 s1_fire;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] ival;
  logic                 hit_long, hit_short;
  logic                 sym_done, sym_val;
  logic                 emit, mismatch;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // Interval from the latched timestamp, or reuse the previous one
  assign now       = TIME_BITS'(s1_data_r.arrival_us);
  assign ival      = s1_data_r.has_timestamp ? (now - last_arrival_r) : last_interval_r;
  assign hit_long  = in_window(CMP_W'(ival), long_r, tol_r);
  assign hit_short = in_window(CMP_W'(ival), short_r, tol_r);

  // Symbol assembly from interval halves
  always_comb begin
    pend_nxt = pend_r;
    sym_done = 1'b0;
    sym_val  = 1'b0;
    case (pend_r)
      PEND_NONE: begin
        if (hit_long) begin
          pend_nxt = PEND_ONE;
        end else if (hit_short) begin
          pend_nxt = PEND_ZERO;
        end
      end
      PEND_ONE: begin
        sym_done = hit_short;
        sym_val  = 1'b1;
        pend_nxt = PEND_NONE;
      end
      PEND_ZERO: begin
        sym_done = hit_long;
        sym_val  = 1'b0;
        pend_nxt = PEND_NONE;
      end
      default: begin
        pend_nxt = PEND_NONE;
      end
    endcase
  end

  // Pair check and next state
  always_comb begin
    last_arrival_nxt  = last_arrival_r;
    last_interval_nxt = last_interval_r;
    phase_nxt         = phase_r;
    held_nxt          = held_r;
    emit              = 1'b0;
    mismatch          = (held_r != sym_val);
    if (s1_fire) begin
      if (s1_data_r.has_timestamp) begin
        last_arrival_nxt  = now;
        last_interval_nxt = ival;
      end
      if (sym_done) begin
        if (phase_r == PHASE_FIRST) begin
          held_nxt  = sym_val;
          phase_nxt = PHASE_SECOND;
        end else begin
          emit = 1'b1;
          if (mismatch) begin
            held_nxt  = sym_val;
            phase_nxt = PHASE_SECOND;
          end else begin
            phase_nxt = PHASE_FIRST;
          end
        end
      end
    end
  end

  // Stage and output register next values
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_fire) begin
      out_valid_nxt          = emit;
      out_data_nxt.data_bit      = held_r;
      out_data_nxt.pair_mismatch = mismatch;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r           <= TOLERANCE_RST;
      short_r         <= SHORT_RST;
      long_r          <= LONG_RST;
      s1_valid_r      <= 1'b0;
      last_arrival_r  <= '0;
      last_interval_r <= '0;
      pend_r          <= PEND_NONE;
      phase_r         <= PHASE_FIRST;
      held_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOLERANCE: tol_r   <= cfg_wdata;
          CFG_SHORT:     short_r <= cfg_wdata;
          CFG_LONG:      long_r  <= cfg_wdata;
          default: ;
        endcase
      end
      s1_valid_r      <= s1_valid_nxt;
      last_arrival_r  <= last_arrival_nxt;
      last_interval_r <= last_interval_nxt;
      if (s1_fire) begin
        pend_r <= pend_nxt;
      end
      phase_r         <= phase_nxt;
      held_r          <= held_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the decode pipeline
  `IPBD_ASSERT(a_ready_when_empty, !s1_valid_r |-> in_ready, "input stage empty but not ready")
  `IPBD_ASSERT(a_emit_second, emit |-> (phase_r == PHASE_SECOND), "result outside second phase")
  `IPBD_ASSERT(a_match_phase, (emit && !mismatch) |=> (phase_r == PHASE_FIRST), "match did not restart pair")
  `IPBD_ASSERT(a_mismatch_phase, (emit && mismatch) |=> (phase_r == PHASE_SECOND && out_valid_r), "mismatch lost")
  `IPBD_ASSERT(a_symbol_pending, sym_done |-> (pend_r != PEND_NONE), "symbol without first half")
  `IPBD_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule
